// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BCCI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BCCI_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/bcci_pkg.sv =====
// Package with types, constants and codes of the bicubic interpolator.
package bcci_pkg;

    // Fixed field widths of the transactions.
    localparam int COORD_W         = 18;
    localparam int COL_W           = 8;
    localparam int CFG_W           = 9;
    localparam int COORD_FRAC_BITS = 10;
    localparam int PIXEL_BITS      = 16;
    localparam int INT_W           = COORD_W - COORD_FRAC_BITS;

    // Defaults of the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Kernel arithmetic.
    localparam int WEIGHT_FRAC = 13;
    localparam int KSHIFT      = 3 * COORD_FRAC_BITS + 1 - WEIGHT_FRAC;
    localparam int KW          = 3 * COORD_FRAC_BITS + 10;
    localparam int WGT_W       = 16;
    localparam int PROD_W      = 2 * WGT_W;
    localparam int MUL_W       = PROD_W + PIXEL_BITS;
    localparam int ACC_W       = MUL_W + 4;

    // Function codes and register indexes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic signed [WGT_W-1:0] wgt_t;
    typedef wgt_t [3:0] wgt_vec_t;

    typedef struct packed {
        logic                         func;
        logic [COL_W-1:0]             pixel_col;
        logic [COL_W-1:0]             pixel_row;
        logic signed [PIXEL_BITS-1:0] pixel_value;
        logic [COORD_W-1:0]           coord_x;
        logic [COORD_W-1:0]           coord_y;
    } in_item_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] interp_value;
        logic                         missing;
    } out_item_t;

    // Control that travels with one tap into the accumulator.
    typedef struct packed {
        logic valid;
        logic first;
    } tap_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KERN,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/bcci_frame_store.sv =====
// Single-ported frame store with a registered read.
module bcci_frame_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [AW-1:0]                         addr,
    input  logic signed [bcci_pkg::PIXEL_BITS-1:0] wdata,
    output logic signed [bcci_pkg::PIXEL_BITS-1:0] rdata
);
    import bcci_pkg::*;

    logic signed [PIXEL_BITS-1:0] mem [DEPTH];
    logic signed [PIXEL_BITS-1:0] rdata_reg;

    // One access per cycle: a write, or a read whose data appears next cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bcci_kernel.sv =====
// Three-stage pipeline that turns a coordinate fraction into four kernel taps.
module bcci_kernel (
    input  logic                                 aclk,
    input  logic [bcci_pkg::COORD_FRAC_BITS-1:0] frac,
    output bcci_pkg::wgt_vec_t                   taps
);
    import bcci_pkg::*;

    localparam int F = COORD_FRAC_BITS;

    logic [F-1:0]     k1_reg;
    logic [2*F-1:0]   k2_reg;
    logic [F-1:0]     kb_reg;
    logic [2*F-1:0]   k2b_reg;
    logic [3*F-1:0]   k3_reg;
    wgt_vec_t         taps_reg;
    logic signed [KW-1:0] k3s, k2ds, kd2s, d3x2;
    logic signed [KW-1:0] t [4];
    logic signed [KW-1:0] half;
    logic signed [KW-1:0] rnd;
    wgt_vec_t         taps_next;

    // Stage one squares, stage two cubes, stage three registers the taps.
    always_ff @(posedge aclk) begin
        k1_reg  <= frac;
        k2_reg  <= frac * frac;
        kb_reg  <= k1_reg;
        k2b_reg <= k2_reg;
        k3_reg  <= k2_reg * k1_reg;
        taps_reg <= taps_next;
    end

    // Polynomial terms with 3F+1 fraction bits, then rounded to the weight format.
    always_comb begin
        k3s  = signed'(KW'(k3_reg));
        k2ds = signed'(KW'(k2b_reg) << F);
        kd2s = signed'(KW'(kb_reg) << (2 * F));
        d3x2 = signed'(KW'(1) << (3 * F + 1));
        half = signed'(KW'(1) << (KSHIFT - 1));
        t[0] = (k2ds <<< 1) - k3s - kd2s;
        t[1] = (k3s <<< 1) + k3s - ((k2ds <<< 2) + k2ds) + d3x2;
        t[2] = (k2ds <<< 2) + kd2s - ((k3s <<< 1) + k3s);
        t[3] = k3s - k2ds;
        rnd  = '0;
        taps_next = '0;
        for (int n = 0; n < 4; n++) begin
            rnd = (t[n] + half) >>> KSHIFT;
            taps_next[n] = rnd[WGT_W-1:0];
        end
    end

    assign taps = taps_reg;

endmodule

// ===== rtl/bcci_mac.sv =====
// Weight product, sample multiply and accumulate, with final rounding and saturation.
module bcci_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bcci_pkg::tap_ctrl_t                   ctrl,
    input  bcci_pkg::wgt_t                        wy,
    input  bcci_pkg::wgt_t                        wx,
    input  logic signed [bcci_pkg::PIXEL_BITS-1:0] pix,
    output logic signed [bcci_pkg::PIXEL_BITS-1:0] result
);
    import bcci_pkg::*;

    tap_ctrl_t               ca_reg, cb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  pix_max, pix_min;

    // Control travels alongside the data stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ca_reg <= '0;
            cb_reg <= '0;
        end else begin
            ca_reg <= ctrl;
            cb_reg <= ca_reg;
        end
    end

    // Data stages: weight product, then sample multiply, then accumulate.
    always_ff @(posedge aclk) begin
        prod_reg <= wy * wx;
        mul_reg  <= pix * prod_reg;
        acc_reg  <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (cb_reg.valid) begin
            acc_next = cb_reg.first ? ACC_W'(mul_reg) : acc_reg + ACC_W'(mul_reg);
        end
    end

    // Round to nearest with ties upward, then clamp to the sample range.
    always_comb begin
        pix_max = signed'(ACC_W'((1 << (PIXEL_BITS - 1)) - 1));
        pix_min = -pix_max - signed'(ACC_W'(1));
        rounded = (acc_reg + signed'(ACC_W'(1) << (2 * WEIGHT_FRAC - 1))) >>> (2 * WEIGHT_FRAC);
        if (rounded > pix_max) begin
            result = pix_max[PIXEL_BITS-1:0];
        end else if (rounded < pix_min) begin
            result = pix_min[PIXEL_BITS-1:0];
        end else begin
            result = rounded[PIXEL_BITS-1:0];
        end
    end

endmodule

// ===== rtl/bicubic_cubic_convolution_interp_top.sv =====
// Top level of the bicubic cubic-convolution interpolator over a frame store.
//
// Input channel s_*: one transaction is either a pixel write (func = write) or a
// query (func = query) with a Q8.10 position. A write is stored and gives no
// result; the block is ready again in the next cycle.
// Output channel m_*: one transaction per query, carrying the interpolated
// sample or the missing flag for positions in the edge band or off the image.
// A query passes through the kernel tap pipeline, then sixteen reads of the
// single-ported frame store (one per cycle), then the drain of the
// multiply-accumulate pipeline and the load of the output register; the next
// transaction is taken in the cycle after the load. A missing query goes from
// acceptance straight to the output load. One query is in work at a time.
// The result sits in an output register; the next transaction is accepted while
// it waits, and a finished query waits there only while the receiver stalls.
// Reset clears control state and sets both size registers to 256;
// the frame store is not cleared and must be written before it is read.
// Configuration writes are taken at any cycle with cfg_we high.
module bicubic_cubic_convolution_interp_top #(
    parameter int MAX_WIDTH  = bcci_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bcci_pkg::MAX_HEIGHT_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  bcci_pkg::in_item_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bcci_pkg::out_item_t      m_data,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [bcci_pkg::CFG_W-1:0] cfg_wdata
);
    import bcci_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int F     = COORD_FRAC_BITS;

    state_t             state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [INT_W-1:0]   ix_reg, iy_reg;
    logic [F-1:0]       fx_reg, fy_reg;
    logic               missing_reg;
    logic [CFG_W-1:0]   width_reg, height_reg;
    out_item_t          out_reg;
    logic               m_valid_reg;

    logic               accept, is_query, is_missing, load_out, cnt_clr;
    logic [INT_W-1:0]   qix, qiy;
    logic [31:0]        nx, ny;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic signed [PIXEL_BITS-1:0] mem_rdata;
    logic [INT_W-1:0]   row, col;
    wgt_vec_t           wx_taps, wy_taps;
    tap_ctrl_t          tap_ctrl;
    logic signed [PIXEL_BITS-1:0] mac_result;

    assign accept   = s_valid && s_ready;
    assign is_query = (s_data.func == FUNC_QUERY);

    // Edge band test on the integer parts against the clamped sizes.
    always_comb begin
        qix = s_data.coord_x[COORD_W-1:F];
        qiy = s_data.coord_y[COORD_W-1:F];
        nx  = (32'(width_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_reg);
        ny  = (32'(height_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_reg);
        is_missing = (qix == '0) || (32'(qix) + 32'd2 >= nx) ||
                     (qiy == '0) || (32'(qiy) + 32'd2 >= ny);
    end

    // Next state of the query sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_query) begin
                    state_next = is_missing ? ST_DONE : ST_KERN;
                end
            end
            ST_KERN: begin
                if (cnt_reg == 4'd2) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (cnt_reg == 4'd15) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == 4'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        cnt_clr  = 1'b1;
        load_out = 1'b0;
        tap_ctrl = '0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_KERN: cnt_clr = (cnt_reg == 4'd2);
            ST_READ: begin
                cnt_clr = (cnt_reg == 4'd15);
                tap_ctrl.valid = 1'b1;
                tap_ctrl.first = (cnt_reg == 4'd0);
            end
            ST_DRAIN: cnt_clr = (cnt_reg == 4'd2);
            ST_DONE:  load_out = !m_valid_reg || m_ready;
            default: ;
        endcase
        cnt_next = cnt_clr ? 4'd0 : cnt_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            width_reg   <= CFG_W'(256);
            height_reg  <= CFG_W'(256);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Query payload and result registers.
    always_ff @(posedge aclk) begin
        if (accept && is_query) begin
            ix_reg      <= qix;
            iy_reg      <= qiy;
            fx_reg      <= s_data.coord_x[F-1:0];
            fy_reg      <= s_data.coord_y[F-1:0];
            missing_reg <= is_missing;
        end
        if (load_out) begin
            out_reg.missing      <= missing_reg;
            out_reg.interp_value <= missing_reg ? '0 : mac_result;
        end
    end

    // Frame store address: a pixel write in idle, or a neighbourhood read.
    always_comb begin
        row      = iy_reg - INT_W'(1) + INT_W'(cnt_reg[3:2]);
        col      = ix_reg - INT_W'(1) + INT_W'(cnt_reg[1:0]);
        mem_we   = 1'b0;
        mem_addr = AW'(32'(row) * 32'(MAX_WIDTH) + 32'(col));
        if (state_reg == ST_IDLE) begin
            mem_we = accept && !is_query && (32'(s_data.pixel_col) < 32'(MAX_WIDTH)) &&
                     (32'(s_data.pixel_row) < 32'(MAX_HEIGHT));
            mem_addr = AW'(32'(s_data.pixel_row) * 32'(MAX_WIDTH) + 32'(s_data.pixel_col));
        end
    end

    bcci_frame_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s_data.pixel_value),
        .rdata (mem_rdata)
    );

    bcci_kernel u_kern_x (
        .aclk (aclk),
        .frac (fx_reg),
        .taps (wx_taps)
    );

    bcci_kernel u_kern_y (
        .aclk (aclk),
        .frac (fy_reg),
        .taps (wy_taps)
    );

    bcci_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tap_ctrl),
        .wy      (wy_taps[cnt_reg[3:2]]),
        .wx      (wx_taps[cnt_reg[1:0]]),
        .pix     (mem_rdata),
        .result  (mac_result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/bcci_checker.sv =====
// Port-level checker for the interpolator, bound to its top level.
`include "assert_macros.svh"

module bcci_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bcci_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input bcci_pkg::out_item_t m_data
);
    import bcci_pkg::*;

    // A stalled result holds its value.
    `BCCI_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // Reset empties the output register.
    `BCCI_ASSERT_RST(a_reset, !aresetn |=> !m_valid, "result valid after reset")

    // A missing result carries a zero sample.
    `BCCI_ASSERT(a_missing, m_valid && m_data.missing |-> m_data.interp_value == '0, "missing result not zero")

    // An accepted query occupies the block for at least the next cycle.
    `BCCI_ASSERT(a_busy, s_valid && s_ready && s_data.func == FUNC_QUERY |=> !s_ready, "ready during a query")

endmodule

bind bicubic_cubic_convolution_interp_top bcci_checker u_chk (.*);
